[src/bthr_pkg.sv]
`default_nettype none
package bthr_pkg;

    localparam int TIME_WIDTH_DEFAULT = 32;
    localparam int FIELD_WIDTH        = 24;
    localparam int APB_ADDR_WIDTH     = 4;
    localparam int APB_DATA_WIDTH     = 32;

    localparam logic [FIELD_WIDTH-1:0] QUICK_WINDOW_RESET = 24'd16384;
    localparam logic [FIELD_WIDTH-1:0] REPEAT_DELAY_RESET = 24'd32768;
    localparam logic [FIELD_WIDTH-1:0] REPEAT_STEP_RESET  = 24'd6554;

    // Register index, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_QUICK_WINDOW = 2'd0,
        REG_REPEAT_DELAY = 2'd1,
        REG_REPEAT_STEP  = 2'd2
    } bthr_reg_t;

    typedef struct packed {
        logic [FIELD_WIDTH-1:0] quick_window;
        logic [FIELD_WIDTH-1:0] rpt_delay;
        logic [FIELD_WIDTH-1:0] rpt_step;
    } bthr_cfg_t;

    typedef struct packed {
        logic press_quick;
        logic press_repeat_seen;
        logic release_quick;
        logic release_repeat_seen;
        logic repeat_fire;
        logic is_held;
        logic hold_start;
        logic press_single;
        logic release_single;
    } bthr_result_t;

endpackage
`default_nettype wire

[src/button_tap_hold_repeat_classifier_unit.sv]
`default_nettype none
// Button tap, hold and auto-repeat classifier. Each input beat is one tick carrying the
// elapsed time (unsigned Q8.16 seconds) and the previous and current button levels; each
// tick yields exactly one result beat with nine flags. A tick passes an input register,
// then timer update and classification into the result register; one tick is accepted
// every cycle while the result side keeps up. The timer state is updated in the same
// cycle as the tick is classified, which is what lets consecutive ticks follow each
// other with no gap. TIME_WIDTH sets the width of the saturating timers. Configuration
// registers sit on the APB port at 0x0 (quick window), 0x4 (repeat delay) and 0x8
// (repeat step); write them only while no tick is in flight.
module button_tap_hold_repeat_classifier_unit
    import bthr_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEFAULT
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,

    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [APB_ADDR_WIDTH-1:0] paddr,
    input  wire logic [APB_DATA_WIDTH-1:0] pwdata,
    output logic      [APB_DATA_WIDTH-1:0] prdata,
    output logic                           pready,

    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [FIELD_WIDTH-1:0]    s_delta_time,
    input  wire logic                      s_level_before,
    input  wire logic                      s_level_now,

    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic                           m_press_quick,
    output logic                           m_press_repeat_seen,
    output logic                           m_release_quick,
    output logic                           m_release_repeat_seen,
    output logic                           m_repeat_fire,
    output logic                           m_is_held,
    output logic                           m_hold_start,
    output logic                           m_press_single,
    output logic                           m_release_single
);

    bthr_cfg_t    cfg;
    bthr_result_t result;

    logic                   in_valid_reg;
    logic [FIELD_WIDTH-1:0] dt_reg;
    logic                   before_reg;
    logic                   now_reg;
    logic                   out_valid_reg;
    bthr_result_t           out_reg;
    logic                   advance;

    assign pready = 1'b1;

    bthr_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // A tick moves into the result register when the result slot is free or drains now.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    bthr_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (advance),
        .delta_time   (dt_reg),
        .level_before (before_reg),
        .level_now    (now_reg),
        .cfg          (cfg),
        .result       (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            dt_reg     <= s_delta_time;
            before_reg <= s_level_before;
            now_reg    <= s_level_now;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid               = out_valid_reg;
    assign m_press_quick         = out_reg.press_quick;
    assign m_press_repeat_seen   = out_reg.press_repeat_seen;
    assign m_release_quick       = out_reg.release_quick;
    assign m_release_repeat_seen = out_reg.release_repeat_seen;
    assign m_repeat_fire         = out_reg.repeat_fire;
    assign m_is_held             = out_reg.is_held;
    assign m_hold_start          = out_reg.hold_start;
    assign m_press_single        = out_reg.press_single;
    assign m_release_single      = out_reg.release_single;

    a_hold_start_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hold_start |-> m_is_held)
        else $error("hold start reported without held status");

    a_edges_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_press_quick && m_release_quick))
        else $error("press and release edge in one tick");

    a_fire_not_on_press: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_repeat_fire |-> !m_press_quick && !m_release_quick)
        else $error("repeat fired on an edge tick");

    a_single_is_quick: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_press_single || m_release_single) |-> m_press_quick || m_release_quick)
        else $error("single press or release without a quick edge");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |=> out_valid_reg && $stable(out_reg))
        else $error("stalled result changed");

endmodule
`default_nettype wire

[src/bthr_regs.sv]
`default_nettype none
module bthr_regs
    import bthr_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [APB_ADDR_WIDTH-1:0] paddr,
    input  wire logic [APB_DATA_WIDTH-1:0] pwdata,
    output logic      [APB_DATA_WIDTH-1:0] prdata,
    output bthr_cfg_t                      cfg
);

    bthr_cfg_t cfg_reg;
    logic      wr_en;
    bthr_reg_t reg_index;

    assign wr_en     = psel && penable && pwrite;
    assign reg_index = bthr_reg_t'(paddr[APB_ADDR_WIDTH-1:2]);
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.quick_window <= QUICK_WINDOW_RESET;
            cfg_reg.rpt_delay    <= REPEAT_DELAY_RESET;
            cfg_reg.rpt_step     <= REPEAT_STEP_RESET;
        end else if (wr_en) begin
            unique case (reg_index)
                REG_QUICK_WINDOW: cfg_reg.quick_window <= pwdata[FIELD_WIDTH-1:0];
                REG_REPEAT_DELAY: cfg_reg.rpt_delay    <= pwdata[FIELD_WIDTH-1:0];
                REG_REPEAT_STEP:  cfg_reg.rpt_step     <= pwdata[FIELD_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            REG_QUICK_WINDOW: prdata = APB_DATA_WIDTH'(cfg_reg.quick_window);
            REG_REPEAT_DELAY: prdata = APB_DATA_WIDTH'(cfg_reg.rpt_delay);
            REG_REPEAT_STEP:  prdata = APB_DATA_WIDTH'(cfg_reg.rpt_step);
            default:          prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

[src/bthr_core.sv]
`default_nettype none
module bthr_core
    import bthr_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEFAULT
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   advance,
    input  wire logic [FIELD_WIDTH-1:0] delta_time,
    input  wire logic                   level_before,
    input  wire logic                   level_now,
    input  wire bthr_cfg_t              cfg,
    output bthr_result_t                result
);

    // Common compare width covers both the timers and the 24-bit fields.
    localparam int CW = (TIME_WIDTH > FIELD_WIDTH) ? TIME_WIDTH : FIELD_WIDTH;
    localparam int SW = CW + 1;
    localparam int RW = CW + 2;

    localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};
    localparam logic signed [RW-1:0]  REP_MAX  = {{(RW-TIME_WIDTH){1'b0}}, {TIME_WIDTH{1'b1}}};
    localparam logic signed [RW-1:0]  REP_MIN  = ~REP_MAX;

    logic [TIME_WIDTH-1:0]  since_rel_reg, since_rel_next;
    logic [TIME_WIDTH-1:0]  since_prs_reg, since_prs_next;
    logic [TIME_WIDTH-1:0]  held_reg, held_next;
    logic signed [TIME_WIDTH:0] rep_reg, rep_next;
    logic quick_press_reg, quick_press_next;
    logic quick_release_reg, quick_release_next;
    logic hold_armed_reg, hold_armed_next;

    function automatic logic [TIME_WIDTH-1:0] sat_add(input logic [TIME_WIDTH-1:0] a,
                                                      input logic [FIELD_WIDTH-1:0] b);
        logic [SW-1:0] s;
        s = SW'(a) + SW'(b);
        return (s > SW'(TIME_MAX)) ? TIME_MAX : s[TIME_WIDTH-1:0];
    endfunction

    function automatic logic signed [TIME_WIDTH:0] rep_clamp(input logic signed [RW-1:0] v);
        logic signed [RW-1:0] c;
        if (v > REP_MAX) begin
            c = REP_MAX;
        end else if (v < REP_MIN) begin
            c = REP_MIN;
        end else begin
            c = v;
        end
        return c[TIME_WIDTH:0];
    endfunction

    logic [TIME_WIDTH-1:0]  rel_sum, prs_sum, held_sum;
    logic [SW-1:0]          qw_ext;
    logic                   clear_flags, flag_press, flag_release;
    logic signed [RW-1:0]   rep_up_ext, dt_ext, delay_ext, step_ext;
    logic signed [TIME_WIDTH:0] rep_up;
    logic                   armed;
    bthr_result_t           res;

    assign qw_ext    = SW'(cfg.quick_window);
    assign dt_ext    = signed'(RW'(delta_time));
    assign delay_ext = signed'(RW'(cfg.rpt_delay));
    assign step_ext  = signed'(RW'(cfg.rpt_step));

    always_comb begin
        rel_sum  = sat_add(since_rel_reg, delta_time);
        prs_sum  = sat_add(since_prs_reg, delta_time);
        held_sum = sat_add(held_reg, delta_time);
        rep_up   = rep_clamp({{(RW-TIME_WIDTH-1){rep_reg[TIME_WIDTH]}}, rep_reg} + dt_ext);
        rep_up_ext = {{(RW-TIME_WIDTH-1){rep_up[TIME_WIDTH]}}, rep_up};

        clear_flags  = (SW'(rel_sum) > qw_ext) || (SW'(prs_sum) > qw_ext);
        flag_press   = quick_press_reg && !clear_flags;
        flag_release = quick_release_reg && !clear_flags;

        res                = '0;
        since_rel_next     = rel_sum;
        since_prs_next     = prs_sum;
        held_next          = '0;
        rep_next           = '0;
        quick_press_next   = flag_press;
        quick_release_next = flag_release;
        hold_armed_next    = 1'b0;
        armed              = hold_armed_reg;

        if (level_now) begin
            held_next = held_sum;
            rep_next  = rep_up;
            if (!level_before) begin
                armed                 = 1'b1;
                res.press_repeat_seen = flag_press;
                if (SW'(rel_sum) < qw_ext) begin
                    res.press_quick  = 1'b1;
                    quick_press_next = 1'b1;
                end
                since_prs_next = '0;
            end else if (rep_up_ext > delay_ext) begin
                res.repeat_fire = 1'b1;
                rep_next        = rep_clamp(rep_up_ext - step_ext);
            end
            if (SW'(held_sum) >= qw_ext) begin
                res.is_held = 1'b1;
                if (armed) begin
                    res.hold_start = 1'b1;
                    armed          = 1'b0;
                end
            end
            hold_armed_next = armed;
        end else if (level_before) begin
            res.release_repeat_seen = flag_release;
            if (SW'(prs_sum) < qw_ext) begin
                res.release_quick  = 1'b1;
                quick_release_next = 1'b1;
            end
            since_rel_next = '0;
        end

        res.press_single   = res.press_quick && !res.press_repeat_seen;
        res.release_single = res.release_quick && !res.release_repeat_seen;
    end

    assign result = res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            since_rel_reg     <= '0;
            since_prs_reg     <= '0;
            held_reg          <= '0;
            rep_reg           <= '0;
            quick_press_reg   <= 1'b0;
            quick_release_reg <= 1'b0;
            hold_armed_reg    <= 1'b0;
        end else if (advance) begin
            since_rel_reg     <= since_rel_next;
            since_prs_reg     <= since_prs_next;
            held_reg          <= held_next;
            rep_reg           <= rep_next;
            quick_press_reg   <= quick_press_next;
            quick_release_reg <= quick_release_next;
            hold_armed_reg    <= hold_armed_next;
        end
    end

endmodule
`default_nettype wire
